[rtl/core/sipnist_pkg.sv]
package sipnist_pkg;

	// transaction phases
	typedef enum logic [1:0] {
		PH_NONE,
		PH_TRYING,
		PH_PROCEEDING,
		PH_COMPLETED
	} phase_t;

	// event kinds
	localparam logic [2:0] CMD_PEER      = 3'd0;
	localparam logic [2:0] CMD_TU        = 3'd1;
	localparam logic [2:0] CMD_TCP_READY = 3'd2;
	localparam logic [2:0] CMD_TX_FAIL   = 3'd3;
	localparam logic [2:0] CMD_TIMEOUT   = 3'd4;

	// transmit outcomes; anything at or above SR_FAILED counts as failed
	localparam logic [1:0] SR_SENT       = 2'd0;
	localparam logic [1:0] SR_CONNECTING = 2'd1;
	localparam logic [1:0] SR_FAILED     = 2'd2;

	// response code classes
	localparam logic [9:0] PROV_LO  = 10'd100;
	localparam logic [9:0] PROV_HI  = 10'd199;
	localparam logic [9:0] FINAL_LO = 10'd200;
	localparam logic [9:0] FINAL_HI = 10'd699;

	// timer token range, zero means no timer
	localparam logic [15:0] TOKEN_NONE  = 16'd0;
	localparam logic [15:0] TOKEN_FIRST = 16'd1;
	localparam logic [15:0] TOKEN_LAST  = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        is_request;
		logic [9:0]  resp_code;
		logic [1:0]  send_result;
		logic [15:0] timer_id;
	} item_t;

	typedef struct packed {
		logic        status;
		logic        send_response;
		logic        deliver_request;
		logic        notify_error;
		logic        start_timer;
		logic [15:0] timer_token;
		logic        stop_timer;
		logic        release_res;
		phase_t      phase_out;
		logic        over_tcp;
	} result_t;

endpackage

[rtl/core/sipnist_in_reg.sv]
module sipnist_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sipnist_pkg::item_t  in_item,
	input  logic                adv,
	output logic                valid_s1,
	output sipnist_pkg::item_t  item_s1
);
	import sipnist_pkg::*;

	// hold only while a registered item cannot move on
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/core/sipnist_ctrl.sv]
module sipnist_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  sipnist_pkg::item_t   item,
	output sipnist_pkg::result_t res
);
	import sipnist_pkg::*;

	phase_t      phase_q, phase_nx;
	logic [9:0]  code_q, code_nx;
	logic        tcp_q, tcp_nx;
	logic [15:0] armed_q, armed_nx;
	logic [15:0] count_q, count_nx;

	// decoded actions of the current item
	logic rej, send, deliver, term, notify, keep_stop_off;
	logic to_try, to_proc, start, wr_code, set_tcp, clr_tcp;
	logic failed, sent;

	assign failed = item.send_result >= SR_FAILED;
	assign sent   = item.send_result == SR_SENT;

	// event decode per phase
	always_comb begin
		logic [9:0] c;
		logic       act_prov, act_fin;
		c = (item.cmd == CMD_TU) ? item.resp_code : code_q;
		act_prov = (phase_q == PH_TRYING) && (c inside {[PROV_LO:PROV_HI]});
		act_fin  = c inside {[FINAL_LO:FINAL_HI]};
		rej = 1'b0; send = 1'b0; deliver = 1'b0; term = 1'b0; notify = 1'b0;
		keep_stop_off = 1'b0; to_try = 1'b0; to_proc = 1'b0; start = 1'b0;
		wr_code = 1'b0; set_tcp = 1'b0; clr_tcp = 1'b0;
		case (phase_q)
			PH_NONE: begin
				if (item.cmd == CMD_PEER) begin
					deliver = 1'b1;
					to_try  = 1'b1;
				end else begin
					rej = 1'b1;
				end
			end
			PH_TRYING, PH_PROCEEDING: begin
				if (item.cmd == CMD_TU) begin
					if (item.is_request) begin
						rej = 1'b1;
					end else begin
						wr_code = 1'b1;
						if (failed) begin
							term = 1'b1; notify = 1'b1;
						end else if (item.send_result == SR_CONNECTING) begin
							set_tcp = 1'b1;
						end else begin
							clr_tcp = 1'b1;
							send    = 1'b1;
							if (act_prov) to_proc = 1'b1;
							else if (act_fin) start = 1'b1;
						end
					end
				end else if (item.cmd == CMD_TCP_READY) begin
					set_tcp = 1'b1;
					if (failed) begin
						term = 1'b1; notify = 1'b1;
					end else begin
						send = sent;
						// tcp is now set, so a final code terminates at once
						if (act_prov) to_proc = 1'b1;
						else if (act_fin) term = 1'b1;
					end
				end else if (item.cmd == CMD_PEER && phase_q == PH_PROCEEDING) begin
					if (!item.is_request) begin
						rej = 1'b1;
					end else begin
						send = sent;
						if (failed) begin
							term = 1'b1; notify = 1'b1;
						end
					end
				end else if (item.cmd == CMD_TX_FAIL && phase_q == PH_PROCEEDING) begin
					term = 1'b1; notify = 1'b1;
				end else begin
					rej = 1'b1;
				end
			end
			PH_COMPLETED: begin
				case (item.cmd)
					CMD_TU: rej = item.is_request;
					CMD_PEER: begin
						if (!item.is_request) begin
							rej = 1'b1;
						end else begin
							send = sent;
							term = failed;
						end
					end
					CMD_TCP_READY: begin
						set_tcp = 1'b1;
						send    = sent;
						term    = failed;
					end
					CMD_TX_FAIL: begin
						term = 1'b1; notify = 1'b1;
					end
					CMD_TIMEOUT: begin
						if (item.timer_id != armed_q) begin
							rej = 1'b1;
						end else begin
							// timer J itself expired: nothing left to stop
							term = 1'b1; keep_stop_off = 1'b1;
						end
					end
					default: rej = 1'b1;
				endcase
			end
			default: rej = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		phase_nx = phase_q;
		code_nx  = code_q;
		tcp_nx   = tcp_q;
		armed_nx = armed_q;
		count_nx = count_q;
		if (term) begin
			phase_nx = PH_NONE;
			code_nx  = 10'd0;
			tcp_nx   = 1'b0;
			armed_nx = TOKEN_NONE;
		end else begin
			if (wr_code) code_nx = item.resp_code;
			if (set_tcp) tcp_nx = 1'b1;
			else if (clr_tcp) tcp_nx = 1'b0;
			if (start) begin
				phase_nx = PH_COMPLETED;
				armed_nx = count_q;
				count_nx = (count_q == TOKEN_LAST) ? TOKEN_FIRST : count_q + 16'd1;
			end else if (to_proc) begin
				phase_nx = PH_PROCEEDING;
			end else if (to_try) begin
				phase_nx = PH_TRYING;
			end
		end
	end

	// result of the item
	always_comb begin
		res.status          = rej;
		res.send_response   = send;
		res.deliver_request = deliver;
		res.notify_error    = notify;
		res.start_timer     = start;
		res.timer_token     = start ? count_q : TOKEN_NONE;
		res.stop_timer      = term && !keep_stop_off && (armed_q != TOKEN_NONE);
		res.release_res     = term;
		res.phase_out       = phase_nx;
		res.over_tcp        = tcp_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			code_q  <= 10'd0;
			tcp_q   <= 1'b0;
			armed_q <= TOKEN_NONE;
			count_q <= TOKEN_FIRST;
		end else if (fire) begin
			phase_q <= phase_nx;
			code_q  <= code_nx;
			tcp_q   <= tcp_nx;
			armed_q <= armed_nx;
			count_q <= count_nx;
		end
	end

endmodule

[rtl/core/sipnist_out_reg.sv]
module sipnist_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  sipnist_pkg::result_t  res,
	output logic                  adv,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sipnist_pkg::result_t  result_s2
);
	import sipnist_pkg::*;

	logic valid_s2;

	// result register frees when empty or when taken this cycle
	assign adv       = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			result_s2 <= res;
		end
	end

endmodule

[rtl/core/sip_non_invite_server_transaction.sv]
// Non-INVITE server transaction controller.
// Result path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_stall is low; the phase logic between the registers is single pass.
// Reset (arst_n low): phase none, stored code 0, udp, no timer armed, next token 1,
// both pipeline registers empty.
module sip_non_invite_server_transaction (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic        is_request,
	input  logic [9:0]  resp_code,
	input  logic [1:0]  send_result,
	input  logic [15:0] timer_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        send_response,
	output logic        deliver_request,
	output logic        notify_error,
	output logic        start_timer,
	output logic [15:0] timer_token,
	output logic        stop_timer,
	output logic        release_res,
	output logic [1:0]  phase_out,
	output logic        over_tcp
);
	import sipnist_pkg::*;

	item_t   in_item, item_s1;
	result_t res, result_s2;
	logic    valid_s1, adv;

	assign in_item.cmd         = cmd;
	assign in_item.is_request  = is_request;
	assign in_item.resp_code   = resp_code;
	assign in_item.send_result = send_result;
	assign in_item.timer_id    = timer_id;

	sipnist_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sipnist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && adv),
		.item   (item_s1),
		.res    (res)
	);

	sipnist_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (valid_s1),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_s2 (result_s2)
	);

	assign status          = result_s2.status;
	assign send_response   = result_s2.send_response;
	assign deliver_request = result_s2.deliver_request;
	assign notify_error    = result_s2.notify_error;
	assign start_timer     = result_s2.start_timer;
	assign timer_token     = result_s2.timer_token;
	assign stop_timer      = result_s2.stop_timer;
	assign release_res     = result_s2.release_res;
	assign phase_out       = result_s2.phase_out;
	assign over_tcp        = result_s2.over_tcp;

endmodule
